// ----- src/magnitude_pointer_accel_top_defines.svh -----
// Assertion macros for the magnitude pointer accelerator checker.
// Depends on nothing; included by the checker file.
`ifndef MAGNITUDE_POINTER_ACCEL_TOP_DEFINES_SVH
`define MAGNITUDE_POINTER_ACCEL_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mpa_pkg.sv -----
// Shared constants for the magnitude pointer accelerator.
// No dependencies; used by the top level, the checker and the testbench.
package mpa_pkg;

  localparam int DELTA_BITS  = 16;
  localparam int DELTA_SHIFT = 16 - DELTA_BITS;

  localparam logic [15:0] UNIT       = 16'd1000;
  localparam logic [31:0] ROOT_PROBE = 32'h4000_0000;

  localparam logic [15:0] MIN_MULT_RESET = 16'd1000;
  localparam logic [15:0] MAX_MULT_RESET = 16'd1500;
  localparam logic [15:0] DIVISOR_RESET  = 16'd10;

  localparam logic [1:0] REG_MIN_MULT = 2'd0;
  localparam logic [1:0] REG_MAX_MULT = 2'd1;
  localparam logic [1:0] REG_DIVISOR  = 2'd2;

  localparam logic [1:0] CMD_X     = 2'd0;
  localparam logic [1:0] CMD_Y     = 2'd1;
  localparam logic [1:0] CMD_OTHER = 2'd2;

  localparam int DIV1_STEPS = 26;

  // ceil(2^38 / 1000) in halves: x / 1000 == (x * recip) >> 38 for x below 2^32
  localparam logic [15:0] RECIP_HI    = 16'h1062;
  localparam logic [15:0] RECIP_LO    = 16'h4DD3;
  localparam int          RECIP_SHIFT = 6;

endpackage

// ----- src/magnitude_pointer_accel_top.sv -----
// Magnitude pointer accelerator: delta scaling by sqrt(x^2+y^2) based gain.
// One shared 17x17 multiplier forms the squares, the root scaling by 1000, the delta
// product and the four-product reciprocal for /1000; the gain uses a 26-step divider.
// No new beat is taken until the result is loaded; a stalled result holds the block.
// Reset (rst, synchronous): clears held axes, output valid, registers to defaults.
// Depends on mpa_pkg.
module magnitude_pointer_accel_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] value,
  input  logic               last_of_report,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] scaled_value
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_ROOT  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_PROD  = 4'd7;
  localparam logic [3:0] S_PREP  = 4'd8;
  localparam logic [3:0] S_RLL   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_RLH   = 4'd11;
  localparam logic [3:0] S_RHL   = 4'd12;
  localparam logic [3:0] S_RHH   = 4'd13;

  logic [3:0]         state;
  logic [15:0]        min_mult, max_mult, divisor;
  logic signed [15:0] held_x, held_y, delta;
  logic               last_flag, is_delta, neg;
  logic [31:0]        sum, racc, probe, q;
  logic [15:0]        rem, den, mult;
  logic [4:0]         cnt;
  logic [33:0]        acc;

  logic               in_take, cfg_wr;
  logic signed [15:0] value_sh, delta_in;
  logic [15:0]        abs_x, abs_y;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [31:0]        root_trial;
  logic               root_ge;
  logic [16:0]        div_trial;
  logic               div_ge;
  logic [15:0]        rem_next;
  logic [31:0]        mult_raw, mult_lo;
  logic [15:0]        mult_next;
  logic [31:0]        prod_abs;
  logic [31:0]        rcp_top;
  logic [22:0]        res_next;
  logic               out_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign value_sh = value <<< mpa_pkg::DELTA_SHIFT;
  assign delta_in = value_sh >>> mpa_pkg::DELTA_SHIFT;

  assign abs_x = held_x[15] ? 16'(-held_x) : held_x;
  assign abs_y = held_y[15] ? 16'(-held_y) : held_y;

  always_comb begin
    unique case (state)
      S_SQX: begin
        mul_a = {1'b0, abs_x};
        mul_b = {1'b0, abs_x};
      end
      S_SQY: begin
        mul_a = {1'b0, abs_y};
        mul_b = {1'b0, abs_y};
      end
      S_SCALE: begin
        mul_a = {1'b0, racc[15:0]};
        mul_b = {1'b0, mpa_pkg::UNIT};
      end
      S_PROD: begin
        mul_a = {delta[15], delta};
        mul_b = {1'b0, mult};
      end
      S_RLL: begin
        mul_a = {1'b0, sum[15:0]};
        mul_b = {1'b0, mpa_pkg::RECIP_LO};
      end
      S_RLH: begin
        mul_a = {1'b0, sum[15:0]};
        mul_b = {1'b0, mpa_pkg::RECIP_HI};
      end
      S_RHL: begin
        mul_a = {1'b0, sum[31:16]};
        mul_b = {1'b0, mpa_pkg::RECIP_LO};
      end
      S_RHH: begin
        mul_a = {1'b0, sum[31:16]};
        mul_b = {1'b0, mpa_pkg::RECIP_HI};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign root_trial = racc + probe;
  assign root_ge    = (sum >= root_trial);

  assign div_trial = {rem, q[31]};
  assign div_ge    = (div_trial >= {1'b0, den});
  assign rem_next  = div_ge ? 16'(div_trial - {1'b0, den}) : div_trial[15:0];

  assign mult_raw  = {16'b0, mpa_pkg::UNIT} + q;
  assign mult_lo   = (mult_raw < {16'b0, min_mult}) ? {16'b0, min_mult} : mult_raw;
  assign mult_next = (mult_lo > {16'b0, max_mult}) ? max_mult : mult_lo[15:0];

  assign prod_abs = sum[31] ? 32'(-sum) : sum;
  // product bits 63:32 of |x| * recip, from the running sum of the lower partials
  assign rcp_top  = {14'b0, acc[33:16]} + mul_p[31:0];
  assign res_next = neg ? 23'(-q[22:0]) : q[22:0];
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mult <= mpa_pkg::MIN_MULT_RESET;
      max_mult <= mpa_pkg::MAX_MULT_RESET;
      divisor  <= mpa_pkg::DIVISOR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mpa_pkg::REG_MIN_MULT: min_mult <= pwdata[15:0];
        mpa_pkg::REG_MAX_MULT: max_mult <= pwdata[15:0];
        mpa_pkg::REG_DIVISOR:  divisor  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mpa_pkg::REG_MIN_MULT: prdata = {16'b0, min_mult};
      mpa_pkg::REG_MAX_MULT: prdata = {16'b0, max_mult};
      mpa_pkg::REG_DIVISOR:  prdata = {16'b0, divisor};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            last_flag <= last_of_report;
            delta     <= delta_in;
            if (cmd == mpa_pkg::CMD_X || cmd == mpa_pkg::CMD_Y) begin
              is_delta <= 1'b1;
              if (cmd == mpa_pkg::CMD_X) begin
                held_x <= delta_in;
              end else begin
                held_y <= delta_in;
              end
              state <= S_SQX;
            end else begin
              is_delta <= 1'b0;
              neg      <= 1'b0;
              q        <= {{16{value[15]}}, value};
              state    <= S_FIN;
            end
          end
        end
        S_SQX: begin
          sum   <= mul_p[31:0];
          state <= S_SQY;
        end
        S_SQY: begin
          sum   <= sum + mul_p[31:0];
          racc  <= '0;
          probe <= mpa_pkg::ROOT_PROBE;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_ge) begin
            sum  <= sum - root_trial;
            racc <= (racc >> 1) + probe;
          end else begin
            racc <= racc >> 1;
          end
          probe <= probe >> 2;
          if (probe[0]) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          q     <= {mul_p[mpa_pkg::DIV1_STEPS-1:0], (32 - mpa_pkg::DIV1_STEPS)'(0)};
          rem   <= '0;
          den   <= (divisor == '0) ? 16'd1 : divisor;
          cnt   <= 5'(mpa_pkg::DIV1_STEPS);
          state <= S_DIV1;
        end
        S_DIV1: begin
          rem <= rem_next;
          q   <= {q[30:0], div_ge};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          mult  <= mult_next;
          state <= S_PROD;
        end
        S_PROD: begin
          sum   <= mul_p[31:0];
          state <= S_PREP;
        end
        S_PREP: begin
          neg   <= sum[31];
          sum   <= prod_abs;
          state <= S_RLL;
        end
        S_RLL: begin
          acc   <= {18'b0, mul_p[31:16]};
          state <= S_RLH;
        end
        S_RLH: begin
          acc   <= acc + {2'b0, mul_p[31:0]};
          state <= S_RHL;
        end
        S_RHL: begin
          acc   <= acc + {2'b0, mul_p[31:0]};
          state <= S_RHH;
        end
        S_RHH: begin
          q     <= rcp_top >> mpa_pkg::RECIP_SHIFT;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            if (is_delta && last_flag) begin
              held_x <= '0;
              held_y <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      scaled_value <= res_next;
    end
  end

endmodule

// ----- src/mpa_checker.sv -----
// Port-level checker for magnitude_pointer_accel_top, with its bind.
// Depends on mpa_pkg and magnitude_pointer_accel_top_defines.svh.
`include "magnitude_pointer_accel_top_defines.svh"

module mpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         cmd,
  input logic signed [15:0] value,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [22:0] scaled_value
);

  logic               delta_take, other_take, out_held, pass_start, pass_ok;
  logic signed [15:0] value_d1, value_d2;

  assign delta_take = in_valid && !in_stall &&
                      (cmd == mpa_pkg::CMD_X || cmd == mpa_pkg::CMD_Y);
  assign other_take = in_valid && !in_stall &&
                      cmd != mpa_pkg::CMD_X && cmd != mpa_pkg::CMD_Y;
  assign out_held   = out_valid && out_stall;
  assign pass_start = other_take && !out_valid;
  assign pass_ok    = out_valid && (scaled_value == 23'(value_d2));

  always_ff @(posedge clk) begin
    value_d1 <= value;
    value_d2 <= value_d1;
  end

  // stalled result beat holds
  `MPA_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(scaled_value), "stalled beat lost")
  // a delta beat keeps the block busy
  `MPA_ASSERT_NXT(a_delta_busy, delta_take, in_stall, "input taken during delta computation")
  // a pass-through beat taken with the output empty goes through the FIN state to the output, value unchanged
  `MPA_ASSERT_NXT(a_pass_thru, pass_start, ##1 pass_ok, "pass-through beat wrong or late")

endmodule

bind magnitude_pointer_accel_top mpa_checker u_mpa_checker (.*);

// ----- tb/magnitude_pointer_accel_top_tb.sv -----
// Testbench for magnitude_pointer_accel_top: predicts every scaled delta from typed state and
// checks each output beat in order, over several register settings with random idling.
// Depends on mpa_pkg and the top level; stands alone otherwise.
`timescale 1ns / 100ps

module magnitude_pointer_accel_top_tb;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam longint MILLI = longint'(mpa_pkg::UNIT);
  localparam int LIMIT = 1000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 172;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] value;
    logic               last;
  } motion_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic signed [15:0] value = '0;
  logic               last_of_report = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [22:0] scaled_value;

  // predictor state and register copies
  logic signed [15:0] held_x = '0;
  logic signed [15:0] held_y = '0;
  logic [15:0]        cfg_min = mpa_pkg::MIN_MULT_RESET;
  logic [15:0]        cfg_max = mpa_pkg::MAX_MULT_RESET;
  logic [15:0]        cfg_div = mpa_pkg::DIVISOR_RESET;

  motion_t            pending_q[$];
  logic [22:0]        scaled_q[$];
  motion_t            drv_item;
  logic [22:0]        want;
  int                 issued = 0;
  int                 accepted = 0;
  int                 checked = 0;
  int                 errors = 0;
  int                 settings = 0;
  int                 cycles = 0;
  int                 send_wait = 0;
  int                 recv_wait = 0;
  bit                 calm = 1'b0;

  magnitude_pointer_accel_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [22:0] scale_event(logic [1:0] c, logic signed [15:0] v,
                                              logic lst);
    logic signed [15:0] narrow;
    logic signed [22:0] passed;
    longint ax, ay, sum, root, trial, div, mult, prod;
    if (c != mpa_pkg::CMD_X && c != mpa_pkg::CMD_Y) begin
      passed = v;
      return passed;
    end
    narrow = v <<< mpa_pkg::DELTA_SHIFT;
    narrow = narrow >>> mpa_pkg::DELTA_SHIFT;
    if (c == mpa_pkg::CMD_X) held_x = narrow;
    else held_y = narrow;
    ax = held_x;
    ay = held_y;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    sum = ax * ax + ay * ay;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= sum) root = trial;
    end
    div = (cfg_div == 16'd0) ? 1 : longint'(cfg_div);
    mult = MILLI + (root * MILLI) / div;
    if (mult < longint'(cfg_min)) mult = longint'(cfg_min);
    if (mult > longint'(cfg_max)) mult = longint'(cfg_max);
    prod = (longint'(narrow) * mult) / MILLI;
    if (lst) begin
      held_x = '0;
      held_y = '0;
    end
    return prod[22:0];
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        scaled_q.push_back(scale_event(cmd, value, last_of_report));
        accepted++;
        send_wait = draw_wait();
      end
      if (in_valid && in_stall) begin
      end else if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        drv_item = pending_q.pop_front();
        cmd <= drv_item.cmd;
        value <= drv_item.value;
        last_of_report <= drv_item.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          $error("scaled_value: expected nothing, actual %0d", scaled_value);
          errors++;
        end else begin
          want = scaled_q.pop_front();
          if (scaled_value !== want) begin
            $error("scaled_value: expected %0d, actual %0d", $signed(want), scaled_value);
            errors++;
          end
        end
        checked++;
        recv_wait = draw_wait();
      end else if (out_valid && recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mpa_pkg::REG_MIN_MULT: cfg_min = v;
      mpa_pkg::REG_MAX_MULT: cfg_max = v;
      mpa_pkg::REG_DIVISOR:  cfg_div = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] dv);
    reg_write(mpa_pkg::REG_MIN_MULT, lo);
    reg_write(mpa_pkg::REG_MAX_MULT, hi);
    reg_write(mpa_pkg::REG_DIVISOR, dv);
    settings++;
  endtask

  task automatic push_item(input logic [1:0] c, input logic signed [15:0] v, input logic lst);
    motion_t m;
    m.cmd = c;
    m.value = v;
    m.last = lst;
    pending_q.push_back(m);
    issued++;
  endtask

  // hold off until every beat sent has come back
  task automatic drain();
    while (accepted != issued || scaled_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: case ($urandom_range(0, 3))
           0: return -16'sd32768;
           1: return 16'sd32767;
           2: return 16'sd0;
           default: return -16'sd1;
         endcase
      2: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($signed($urandom_range(0, 254)) - 127);
    endcase
  endfunction

  function automatic logic [15:0] rand_bound(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic fill_random(input int n);
    int count;
    logic [1:0] first_axis, second_axis;
    count = 0;
    while (count < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          first_axis = $urandom_range(0, 1) ? mpa_pkg::CMD_X : mpa_pkg::CMD_Y;
          second_axis = (first_axis == mpa_pkg::CMD_X) ? mpa_pkg::CMD_Y : mpa_pkg::CMD_X;
          push_item(first_axis, rand_delta(), 1'b0);
          push_item(second_axis, rand_delta(), 1'b1);
          count += 2;
        end
        6: begin
          push_item(mpa_pkg::CMD_X, rand_delta(), 1'b0);
          count++;
        end
        7: begin
          push_item(mpa_pkg::CMD_Y, rand_delta(), 1'($urandom_range(0, 1)));
          count++;
        end
        default: begin
          push_item($urandom_range(0, 1) ? mpa_pkg::CMD_OTHER : CMD_SPARE, 16'($urandom),
                    1'($urandom_range(0, 1)));
          count++;
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] dv;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    settings++;
    push_item(mpa_pkg::CMD_X, 16'sd0, 1'b0);
    push_item(mpa_pkg::CMD_Y, 16'sd0, 1'b1);
    push_item(mpa_pkg::CMD_X, 16'sd1, 1'b0);
    push_item(mpa_pkg::CMD_Y, -16'sd1, 1'b1);
    push_item(mpa_pkg::CMD_X, -16'sd32768, 1'b0);
    push_item(mpa_pkg::CMD_Y, -16'sd32768, 1'b0);
    push_item(mpa_pkg::CMD_X, 16'sd32767, 1'b1);
    push_item(mpa_pkg::CMD_OTHER, -16'sd32768, 1'b1);
    push_item(mpa_pkg::CMD_Y, 16'sd25, 1'b0);
    push_item(CMD_SPARE, 16'sd32767, 1'b1);
    push_item(mpa_pkg::CMD_X, -16'sd40, 1'b1);
    push_item(mpa_pkg::CMD_X, 16'sd7, 1'b0);
    push_item(mpa_pkg::CMD_Y, 16'sd13, 1'b1);
    push_item(mpa_pkg::CMD_OTHER, 16'sd0, 1'b0);
    drain();

    // widest gain range, full magnitude
    set_regs(16'd0, 16'hFFFF, 16'd1);
    push_item(mpa_pkg::CMD_X, -16'sd32768, 1'b0);
    push_item(mpa_pkg::CMD_Y, -16'sd32768, 1'b0);
    push_item(mpa_pkg::CMD_X, 16'sd32767, 1'b1);
    push_item(mpa_pkg::CMD_Y, 16'sd1, 1'b1);
    drain();

    // crossed clamps, zero divisor
    set_regs(16'hFFFF, 16'd0, 16'd0);
    push_item(mpa_pkg::CMD_X, 16'sd300, 1'b0);
    push_item(mpa_pkg::CMD_Y, -16'sd300, 1'b1);
    push_item(CMD_SPARE, -16'sd2, 1'b0);
    drain();

    // fixed gain, largest divisor
    set_regs(16'd2000, 16'd2000, 16'hFFFF);
    push_item(mpa_pkg::CMD_X, 16'sd1000, 1'b0);
    push_item(mpa_pkg::CMD_Y, -16'sd7, 1'b1);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph % 3 == 2);
      dv = ($urandom_range(0, 3) == 0) ? rand_bound(1, 65535) : 16'($urandom_range(1, 200));
      set_regs(rand_bound(0, 1200), rand_bound(1000, 8000), dv);
      fill_random(PHASE_ITEMS);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Run covered %0d events under %0d register settings; %0d results checked.",
             accepted, settings, checked);
    $display("Clamp extremes, crossed clamps, zero divisor and pass-through events included.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
